// ----- src/ssdtm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ssdtm_pkg;

  localparam int unsigned SumW = 28;
  localparam int unsigned PosW = 10;
  localparam int unsigned PixW = 24;
  localparam logic [SumW-1:0] StartBound = 28'd200000000;

  typedef enum logic [1:0] {
    CfgTemplateWidth  = 2'd0,
    CfgTemplateHeight = 2'd1,
    CfgWindowWidth    = 2'd2,
    CfgWindowHeight   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain,
    StDone
  } state_e;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  best_x;
    logic [5:0]  best_y;
    logic [27:0] best_distance;
  } out_item_t;

  typedef struct packed {
    logic            vld;
    logic            first;
    logic            lastp;
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [PixW-1:0] tpix;
    logic [PixW-1:0] wpix;
    logic [SumW-1:0] sum;
  } cell_bus_t;

endpackage
`default_nettype wire

// ----- src/ssdtm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ssdtm_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ssdtm_pkg::cell_bus_t  bus_i,
  output ssdtm_pkg::cell_bus_t       bus_o
);
  import ssdtm_pkg::*;

  cell_bus_t  bus_d, bus_q;
  logic [7:0] a, b, d;

  always_comb begin
    a = bus_i.tpix[PixW-1 -: 8];
    b = bus_i.wpix[PixW-1 -: 8];
    d = (a > b) ? (a - b) : (b - a);
    bus_d = bus_i;
    bus_d.tpix = {bus_i.tpix[PixW-9:0], 8'd0};
    bus_d.wpix = {bus_i.wpix[PixW-9:0], 8'd0};
    bus_d.sum = bus_i.sum + SumW'(d) * SumW'(d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q <= '0;
    end else begin
      bus_q <= bus_d;
    end
  end

  assign bus_o = bus_q;

endmodule
`default_nettype wire

// ----- src/ssd_template_match_search.sv -----
// The block takes a new pixel load every cycle while idle.
// The final window pixel starts a search that feeds one template pixel per cycle
// through a chain of three channel cells; busy stays high.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears counters, returns config registers to their defaults and sets the best
// match to the start bound at position (0,0); stores are left undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module ssd_template_match_search #(
  parameter int unsigned MAX_TEMPLATE_WIDTH  = 32,
  parameter int unsigned MAX_TEMPLATE_HEIGHT = 32,
  parameter int unsigned MAX_WINDOW_WIDTH    = 64,
  parameter int unsigned MAX_WINDOW_HEIGHT   = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ssdtm_pkg::in_item_t  in_item_i,
  output logic                      result_valid_o,
  output ssdtm_pkg::out_item_t      result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [7:0]           cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);
  import ssdtm_pkg::*;

  localparam int unsigned TDepth = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int unsigned WDepth = MAX_WINDOW_WIDTH * MAX_WINDOW_HEIGHT;
  localparam int unsigned TaW = (TDepth > 1) ? $clog2(TDepth) : 1;
  localparam int unsigned WaW = $clog2(WDepth);
  localparam int unsigned TwW = $clog2(MAX_TEMPLATE_WIDTH + 1);
  localparam int unsigned ThW = $clog2(MAX_TEMPLATE_HEIGHT + 1);
  localparam int unsigned WwW = $clog2(MAX_WINDOW_WIDTH + 1);
  localparam int unsigned WhW = $clog2(MAX_WINDOW_HEIGHT + 1);
  localparam int unsigned XW = $clog2(MAX_WINDOW_WIDTH);
  localparam int unsigned YW = $clog2(MAX_WINDOW_HEIGHT);
  localparam int unsigned CW = (MAX_TEMPLATE_WIDTH > 1) ? $clog2(MAX_TEMPLATE_WIDTH) : 1;
  localparam int unsigned RW = (MAX_TEMPLATE_HEIGHT > 1) ? $clog2(MAX_TEMPLATE_HEIGHT) : 1;
  localparam int unsigned NCells = 3;

  state_e state_q, state_d;
  logic [5:0] tw_q, th_q;
  logic [6:0] ww_q, wh_q;
  logic [TwW-1:0] twc;
  logic [ThW-1:0] thc;
  logic [WwW-1:0] wwc;
  logic [WhW-1:0] whc;
  logic [TaW:0] tsize;
  logic [WaW:0] wsize;
  logic [TaW-1:0] tcnt_q, tcnt_d, tld;
  logic [WaW-1:0] wcnt_q, wcnt_d, wld;
  logic fits;
  logic [XW-1:0] limx;
  logic [YW-1:0] limy;
  logic [XW-1:0] px_q, px_d;
  logic [YW-1:0] py_q, py_d;
  logic [CW-1:0] c_q, c_d;
  logic [RW-1:0] r_q, r_d;
  logic [TaW-1:0] traddr;
  logic [WaW-1:0] wraddr;
  logic accept, issue, c_end, r_end, x_end, y_end;
  logic [PixW-1:0] tmem [TDepth];
  logic [PixW-1:0] wmem [WDepth];
  logic [PixW-1:0] tpix_q, wpix_q, pix;
  logic s0_vld_q, s0_first_q, s0_lastp_q;
  logic [XW-1:0] s0_px_q;
  logic [YW-1:0] s0_py_q;
  cell_bus_t chain [NCells+1];
  cell_bus_t tail;
  logic [SumW-1:0] acc_q, acc_d, best_q, best_d;
  logic [XW-1:0] bx_q, bx_d;
  logic [YW-1:0] by_q, by_d;
  logic chain_busy;

  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;
  assign pix = {in_item_i.red, in_item_i.green, in_item_i.blue};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= 6'd16;
      th_q <= 6'd16;
      ww_q <= 7'd48;
      wh_q <= 7'd48;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        8'(CfgTemplateWidth):  tw_q <= cfg_data_i[5:0];
        8'(CfgTemplateHeight): th_q <= cfg_data_i[5:0];
        8'(CfgWindowWidth):    ww_q <= cfg_data_i[6:0];
        8'(CfgWindowHeight):   wh_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tw_q == '0) twc = TwW'(1);
    else if (32'(tw_q) > MAX_TEMPLATE_WIDTH) twc = TwW'(MAX_TEMPLATE_WIDTH);
    else twc = TwW'(tw_q);
    if (th_q == '0) thc = ThW'(1);
    else if (32'(th_q) > MAX_TEMPLATE_HEIGHT) thc = ThW'(MAX_TEMPLATE_HEIGHT);
    else thc = ThW'(th_q);
    if (ww_q == '0) wwc = WwW'(1);
    else if (32'(ww_q) > MAX_WINDOW_WIDTH) wwc = WwW'(MAX_WINDOW_WIDTH);
    else wwc = WwW'(ww_q);
    if (wh_q == '0) whc = WhW'(1);
    else if (32'(wh_q) > MAX_WINDOW_HEIGHT) whc = WhW'(MAX_WINDOW_HEIGHT);
    else whc = WhW'(wh_q);
    tsize = (TaW+1)'((TaW+1)'(twc) * (TaW+1)'(thc));
    wsize = (WaW+1)'((WaW+1)'(wwc) * (WaW+1)'(whc));
    fits = (32'(wwc) >= 32'(twc)) && (32'(whc) >= 32'(thc));
    limx = XW'(32'(wwc) - 32'(twc));
    limy = YW'(32'(whc) - 32'(thc));
    tld = ((TaW+1)'(tcnt_q) < tsize) ? tcnt_q : '0;
    wld = ((WaW+1)'(wcnt_q) < wsize) ? wcnt_q : '0;
  end

  always_comb begin
    tcnt_d = tcnt_q;
    wcnt_d = wcnt_q;
    if (accept) begin
      if (!in_item_i.func) begin
        tcnt_d = ((TaW+1)'(tld) + 1'b1 == tsize) ? '0 : tld + 1'b1;
      end else if (in_item_i.last) begin
        wcnt_d = '0;
      end else begin
        wcnt_d = ((WaW+1)'(wld) + 1'b1 == wsize) ? '0 : wld + 1'b1;
      end
    end
  end

  assign issue = (state_q == StRun);
  assign c_end = (32'(c_q) == 32'(twc) - 1);
  assign r_end = (32'(r_q) == 32'(thc) - 1);
  assign x_end = (px_q == limx);
  assign y_end = (py_q == limy);
  assign traddr = TaW'((TaW+1)'(r_q) * (TaW+1)'(twc) + (TaW+1)'(c_q));
  assign wraddr = WaW'(((WaW+1)'(py_q) + (WaW+1)'(r_q)) * (WaW+1)'(wwc)
                       + (WaW+1)'(px_q) + (WaW+1)'(c_q));

  always_ff @(posedge clk_i) begin
    if (accept && !in_item_i.func) tmem[tld] <= pix;
    if (accept && in_item_i.func) wmem[wld] <= pix;
    tpix_q <= tmem[traddr];
    wpix_q <= wmem[wraddr];
  end

  always_comb begin
    chain_busy = s0_vld_q;
    for (int i = 1; i <= NCells; i++) chain_busy = chain_busy | chain[i].vld;
  end

  always_comb begin
    state_d = state_q;
    px_d = px_q;
    py_d = py_q;
    c_d = c_q;
    r_d = r_q;
    unique case (state_q)
      StIdle: begin
        if (accept && in_item_i.func && in_item_i.last) begin
          px_d = '0;
          py_d = '0;
          c_d = '0;
          r_d = '0;
          state_d = fits ? StRun : StDone;
        end
      end
      StRun: begin
        c_d = c_q + 1'b1;
        if (c_end) begin
          c_d = '0;
          r_d = r_q + 1'b1;
          if (r_end) begin
            r_d = '0;
            px_d = px_q + 1'b1;
            if (x_end) begin
              px_d = '0;
              py_d = py_q + 1'b1;
              if (y_end) state_d = StDrain;
            end
          end
        end
      end
      StDrain: begin
        if (!chain_busy) state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    chain[0] = '0;
    chain[0].vld = s0_vld_q;
    chain[0].first = s0_first_q;
    chain[0].lastp = s0_lastp_q;
    chain[0].px = PosW'(s0_px_q);
    chain[0].py = PosW'(s0_py_q);
    chain[0].tpix = tpix_q;
    chain[0].wpix = wpix_q;
  end

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    ssdtm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bus_i  (chain[g]),
      .bus_o  (chain[g+1])
    );
  end

  assign tail = chain[NCells];

  always_comb begin
    acc_d = acc_q;
    best_d = best_q;
    bx_d = bx_q;
    by_d = by_q;
    if (state_q == StIdle && accept && in_item_i.func && in_item_i.last) begin
      best_d = StartBound;
      bx_d = '0;
      by_d = '0;
    end else if (tail.vld) begin
      acc_d = tail.first ? tail.sum : acc_q + tail.sum;
      if (tail.lastp && acc_d <= best_q) begin
        best_d = acc_d;
        bx_d = XW'(tail.px);
        by_d = YW'(tail.py);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tcnt_q <= '0;
      wcnt_q <= '0;
      px_q <= '0;
      py_q <= '0;
      c_q <= '0;
      r_q <= '0;
      s0_vld_q <= 1'b0;
      s0_first_q <= 1'b0;
      s0_lastp_q <= 1'b0;
      s0_px_q <= '0;
      s0_py_q <= '0;
      acc_q <= '0;
      best_q <= StartBound;
      bx_q <= '0;
      by_q <= '0;
    end else begin
      state_q <= state_d;
      tcnt_q <= tcnt_d;
      wcnt_q <= wcnt_d;
      px_q <= px_d;
      py_q <= py_d;
      c_q <= c_d;
      r_q <= r_d;
      s0_vld_q <= issue;
      s0_first_q <= (c_q == '0) && (r_q == '0);
      s0_lastp_q <= c_end && r_end;
      s0_px_q <= px_q;
      s0_py_q <= py_q;
      acc_q <= acc_d;
      best_q <= best_d;
      bx_q <= bx_d;
      by_q <= by_d;
    end
  end

  assign busy = (state_q != StIdle);
  assign result_valid_o = (state_q == StDone);
  assign result_o.best_x = 6'(bx_q);
  assign result_o.best_y = 6'(by_q);
  assign result_o.best_distance = best_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside a search");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy) else $error("block still busy after result");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.best_distance <= StartBound) else $error("best above bound");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !chain_busy) else $error("result while chain still holds items");

endmodule
`default_nettype wire
